// ----- rtl/bdlp_pkg.sv -----
package bdlp_pkg;

   // number of buttons with state; the sample index field is fixed at 3 bits
   localparam int NUM_BUTTONS = 8;
   localparam int BTN_W       = $clog2(NUM_BUTTONS);

   // event queue between the state update and the result port
   localparam int EVQ_DEPTH = 4;
   localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
   localparam int EVQ_CNT_W = EVQ_PTR_W + 1;

   typedef enum logic [1:0] {
      KIND_PRESS   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_LONG    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REG_DEBOUNCE_TIME   = 2'd0,
      REG_LONG_PRESS_TIME = 2'd1,
      REG_ACTIVE_LOW_MASK = 2'd2,
      REG_ENABLE_MASK     = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] long_press_time;
      logic [7:0]  active_low_mask;
      logic [7:0]  enable_mask;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  button;
      kind_type    kind;
      logic [31:0] time_ms;
      logic        last;
   } evt_type;

   // up to two events per sample; two implies one
   typedef struct packed {
      logic    one;
      logic    two;
      evt_type ev0;
      evt_type ev1;
   } push_type;

endpackage

// ----- rtl/bdlp_csr.sv -----
module bdlp_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   output bdlp_pkg::cfg_type cfg
);
   import bdlp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_DEBOUNCE_TIME:   cfg_in.debounce_time   = csr_wdata;
            REG_LONG_PRESS_TIME: cfg_in.long_press_time = csr_wdata;
            REG_ACTIVE_LOW_MASK: cfg_in.active_low_mask = csr_wdata[7:0];
            REG_ENABLE_MASK:     cfg_in.enable_mask     = csr_wdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= 16'd50;
         cfg_ff.long_press_time <= 16'd1000;
         cfg_ff.active_low_mask <= 8'hFF;
         cfg_ff.enable_mask     <= 8'h00;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/bdlp_core.sv -----
module bdlp_core (
   input  logic               clock,
   input  logic               reset,
   input  bdlp_pkg::cfg_type  cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_button_index,
   input  logic               req_raw_level,
   input  logic [31:0]        req_now_ms,
   input  logic               room_two,
   output bdlp_pkg::push_type push
);
   import bdlp_pkg::*;

   // sample register
   logic        s1_valid_ff, s1_valid_in;
   logic [2:0]  s1_button_ff;
   logic        s1_raw_ff;
   logic [31:0] s1_now_ff;

   // per button state
   logic [NUM_BUTTONS-1:0] last_raw_ff;
   logic [NUM_BUTTONS-1:0] stable_pressed_ff;
   logic [NUM_BUTTONS-1:0] long_reported_ff;
   logic [31:0]            change_time_ff [NUM_BUTTONS];
   logic [31:0]            pressed_since_ff [NUM_BUTTONS];

   logic             proc, accept, active, in_range;
   logic [BTN_W-1:0] idx;
   logic             pressed, changed, settled, flip, new_stable, lrep, long_ev;
   logic [31:0]      ct, ps;

   assign proc      = s1_valid_ff && room_two;
   assign req_stall = s1_valid_ff && !room_two;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (proc) begin
         s1_valid_in = 1'b0;
      end
   end

   assign idx      = s1_button_ff[BTN_W-1:0];
   assign in_range = 32'(s1_button_ff) < NUM_BUTTONS;
   assign active   = proc && in_range && cfg.enable_mask[idx];

   always_comb begin
      pressed    = s1_raw_ff ^ cfg.active_low_mask[idx];
      changed    = pressed != last_raw_ff[idx];
      ct         = changed ? s1_now_ff : change_time_ff[idx];
      settled    = (s1_now_ff - ct) >= {16'd0, cfg.debounce_time};
      flip       = settled && (pressed != stable_pressed_ff[idx]);
      new_stable = flip ? pressed : stable_pressed_ff[idx];
      ps         = (flip && pressed) ? s1_now_ff : pressed_since_ff[idx];
      lrep       = (flip && pressed) ? 1'b0 : long_reported_ff[idx];
      long_ev    = settled && new_stable && !lrep
                   && ((s1_now_ff - ps) >= {16'd0, cfg.long_press_time});
   end

   always_comb begin
      push.one = active && (flip || long_ev);
      push.two = active && flip && long_ev;

      push.ev0.button  = s1_button_ff;
      push.ev0.time_ms = s1_now_ff;
      push.ev0.kind    = flip ? (pressed ? KIND_PRESS : KIND_RELEASE) : KIND_LONG;
      push.ev0.last    = !(flip && long_ev);

      push.ev1.button  = s1_button_ff;
      push.ev1.time_ms = s1_now_ff;
      push.ev1.kind    = KIND_LONG;
      push.ev1.last    = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_button_ff <= req_button_index;
         s1_raw_ff    <= req_raw_level;
         s1_now_ff    <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff       <= '0;
         stable_pressed_ff <= '0;
         long_reported_ff  <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            change_time_ff[i]   <= '0;
            pressed_since_ff[i] <= '0;
         end
      end else if (active) begin
         last_raw_ff[idx]       <= pressed;
         stable_pressed_ff[idx] <= new_stable;
         long_reported_ff[idx]  <= lrep || long_ev;
         change_time_ff[idx]    <= ct;
         pressed_since_ff[idx]  <= ps;
      end
   end

   a_two_needs_one : assert property (@(posedge clock) disable iff (reset)
      push.two |-> push.one)
      else $error("second event without first");

   a_two_is_press_long : assert property (@(posedge clock) disable iff (reset)
      push.two |-> (push.ev0.kind == KIND_PRESS && push.ev1.kind == KIND_LONG))
      else $error("event pair is not press then long press");

   a_release_clears : assert property (@(posedge clock) disable iff (reset)
      (push.one && push.ev0.kind == KIND_RELEASE) |=>
         !stable_pressed_ff[$past(idx)])
      else $error("release left button pressed");

endmodule

// ----- rtl/bdlp_evq.sv -----
module bdlp_evq (
   input  logic               clock,
   input  logic               reset,
   input  bdlp_pkg::push_type push,
   output logic               room_two,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_event_button,
   output logic [1:0]         rsp_event_kind,
   output logic [31:0]        rsp_event_time,
   output logic               rsp_last_event
);
   import bdlp_pkg::*;

   evt_type              q_ff [EVQ_DEPTH];
   logic [EVQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_nxt;
   logic [EVQ_CNT_W-1:0] count_ff, count_in;
   logic                 pop;
   evt_type              head;

   assign room_two  = count_ff <= EVQ_CNT_W'(EVQ_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_nxt    = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.two) begin
         wr_ptr_in = wr_ptr_ff + EVQ_PTR_W'(2);
      end else if (push.one) begin
         wr_ptr_in = wr_nxt;
      end
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + EVQ_CNT_W'(push.one) + EVQ_CNT_W'(push.two)
                  - EVQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.one) begin
         q_ff[wr_ptr_ff] <= push.ev0;
      end
      if (push.two) begin
         q_ff[wr_nxt] <= push.ev1;
      end
   end

   assign head             = q_ff[rd_ptr_ff];
   assign rsp_event_button = head.button;
   assign rsp_event_kind   = head.kind;
   assign rsp_event_time   = head.time_ms;
   assign rsp_last_event   = head.last;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= EVQ_CNT_W'(EVQ_DEPTH))
      else $error("event queue overflow");

   a_push_fits : assert property (@(posedge clock) disable iff (reset)
      push.one |-> room_two)
      else $error("push without room");

   a_drain_last : assert property (@(posedge clock) disable iff (reset)
      (pop && count_ff == EVQ_CNT_W'(1) && !push.one) |=> !rsp_valid)
      else $error("queue not empty after last transfer");

endmodule

// ----- rtl/button_debounce_long_press_unit.sv -----
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_stall | button_index, raw_level, now_ms
// rsp     | out       | rsp_valid / rsp_stall | event_button, event_kind, event_time, last_event
// csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// one sample a cycle unless req_stall holds it: sample register, then one pass over the button state
// a result is registered in the sample register and then in the event queue before it appears
// a sample may give two events; the 4-entry event queue drains one a cycle while rsp_stall is low
// req_stall rises while a sample waits in the sample register and the queue
// has fewer than two free slots
// synchronous active-high reset: all button state cleared, registers to defaults
module button_debounce_long_press_unit (
   input  logic        clock,
   input  logic        reset,
   // sample transfer
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_button_index,
   input  logic        req_raw_level,
   input  logic [31:0] req_now_ms,
   // event transfer
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_button,
   output logic [1:0]  rsp_event_kind,
   output logic [31:0] rsp_event_time,
   output logic        rsp_last_event,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bdlp_pkg::*;

   cfg_type  cfg;
   push_type push;
   logic     room_two;

   // debounce time, long press time, polarity and enable masks
   bdlp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sample register and per button debounce / long press state
   bdlp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_button_index (req_button_index),
      .req_raw_level    (req_raw_level),
      .req_now_ms       (req_now_ms),
      .room_two         (room_two),
      .push             (push)
   );

   // events wait here so a stalled result blocks sampling only once fewer than two slots are free
   bdlp_evq u_evq (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .room_two         (room_two),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_button (rsp_event_button),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_time   (rsp_event_time),
      .rsp_last_event   (rsp_last_event)
   );

endmodule

// ----- sim/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bdlp_pkg::*;

   // one scan sample as it goes out on the req channel
   typedef struct {
      logic [2:0]  button;
      logic        level;
      logic [31:0] now_ms;
   } sample_type;

   // clock, reset and block ports; the ones the bench drives are known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_button_index = '0;
   logic        req_raw_level = 1'b0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_button;
   logic [1:0]  rsp_event_kind;
   logic [31:0] rsp_event_time;
   logic        rsp_last_event;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // scan samples waiting for the driver, and events still owed by the block
   sample_type  sample_queue[$];
   evt_type     expected_events[$];

   // register copy, starts at the reset defaults of the block
   cfg_type     shadow_cfg = '{16'd50, 16'd1000, 8'hFF, 8'h00};

   // per-button debounce state of the predictor, cleared like the block's
   logic        raw_pressed[NUM_BUTTONS] = '{default: 1'b0};
   logic [31:0] raw_since[NUM_BUTTONS]   = '{default: 32'd0};
   logic        debounced[NUM_BUTTONS]   = '{default: 1'b0};
   logic [31:0] press_start[NUM_BUTTONS] = '{default: 32'd0};
   logic        long_sent[NUM_BUTTONS]   = '{default: 1'b0};

   // stimulus shaping: intended pin level per button and the running scan time
   logic        target_level[NUM_BUTTONS] = '{default: 1'b0};
   logic [31:0] scan_ms = '0;

   // no random idling on either side while set
   logic        calm = 1'b0;

   int          mismatch_count = 0;
   int          samples_sent = 0;
   int          events_seen = 0;
   int          settings_used = 0;
   int          kind_count[3] = '{default: 0};

   button_debounce_long_press_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_button_index (req_button_index),
      .req_raw_level    (req_raw_level),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_button (rsp_event_button),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_time   (rsp_event_time),
      .rsp_last_event   (rsp_last_event),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one line per mismatch
   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // debounce and long-press prediction for one accepted sample
   function automatic void debounce_predict(input logic [2:0] b, input logic lvl,
                                            input logic [31:0] now);
      logic        now_pressed;
      logic [31:0] held_for;
      evt_type     ev[2];
      int          n;
      int          i;
      n = 0;
      // disabled button: no state change, no event
      if (!shadow_cfg.enable_mask[b]) return;
      now_pressed = lvl ^ shadow_cfg.active_low_mask[b];
      if (now_pressed != raw_pressed[b]) begin
         raw_pressed[b] = now_pressed;
         raw_since[b]   = now;
      end
      // all differences wrap modulo 2^32
      held_for = now - raw_since[b];
      if (held_for >= {16'd0, shadow_cfg.debounce_time}) begin
         if (raw_pressed[b] != debounced[b]) begin
            debounced[b] = raw_pressed[b];
            if (debounced[b]) begin
               press_start[b] = now;
               long_sent[b]   = 1'b0;
               ev[n] = '{b, KIND_PRESS, now, 1'b0};
            end else begin
               ev[n] = '{b, KIND_RELEASE, now, 1'b0};
            end
            n++;
         end
         held_for = now - press_start[b];
         // long press once per press, may share the sample with the press itself
         if (debounced[b] && !long_sent[b] &&
             held_for >= {16'd0, shadow_cfg.long_press_time}) begin
            long_sent[b] = 1'b1;
            ev[n] = '{b, KIND_LONG, now, 1'b0};
            n++;
         end
      end
      for (i = 0; i < n; i++) begin
         ev[i].last = (i == n - 1);
         expected_events.push_back(ev[i]);
      end
   endfunction

   // sample driver: predicts on each transfer, then offers the next sample
   always @(posedge clock) begin
      sample_type next_sample;
      logic       taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && !req_stall;
         if (taken) begin
            debounce_predict(req_button_index, req_raw_level, req_now_ms);
            samples_sent++;
         end
         // a stalled sample stays put until it transfers
         if (!req_valid || taken) begin
            if (sample_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 21)) begin
               next_sample = sample_queue.pop_front();
               req_valid        <= 1'b1;
               req_button_index <= next_sample.button;
               req_raw_level    <= next_sample.level;
               req_now_ms       <= next_sample.now_ms;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // event monitor: every transfer is checked against the oldest expected event
   always @(posedge clock) begin
      evt_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            events_seen++;
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("unexpected event button %0d kind %0d time %0h",
                                         rsp_event_button, rsp_event_kind, rsp_event_time));
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_button !== want.button)
                  report_mismatch($sformatf("event_button %0d, expected %0d",
                                            rsp_event_button, want.button));
               if (rsp_event_kind !== want.kind)
                  report_mismatch($sformatf("event_kind %0d, expected %s",
                                            rsp_event_kind, want.kind.name()));
               else
                  kind_count[want.kind]++;
               if (rsp_event_time !== want.time_ms)
                  report_mismatch($sformatf("event_time %0h, expected %0h",
                                            rsp_event_time, want.time_ms));
               if (rsp_last_event !== want.last)
                  report_mismatch($sformatf("last_event %0b, expected %0b",
                                            rsp_last_event, want.last));
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 21);
      end
   end

   // one register write; valid drops for a cycle between writes
   task automatic write_reg(input reg_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_DEBOUNCE_TIME:   shadow_cfg.debounce_time   = value;
         REG_LONG_PRESS_TIME: shadow_cfg.long_press_time = value;
         REG_ACTIVE_LOW_MASK: shadow_cfg.active_low_mask = value[7:0];
         REG_ENABLE_MASK:     shadow_cfg.enable_mask     = value[7:0];
      endcase
   endtask

   task automatic apply_setting(input logic [15:0] db, input logic [15:0] lp,
                                input logic [7:0] low_mask, input logic [7:0] en_mask);
      write_reg(REG_DEBOUNCE_TIME, db);
      write_reg(REG_LONG_PRESS_TIME, lp);
      write_reg(REG_ACTIVE_LOW_MASK, {8'd0, low_mask});
      write_reg(REG_ENABLE_MASK, {8'd0, en_mask});
      settings_used++;
   endtask

   // all samples sent, all events back, then a short wait for samples without events;
   // checked on the falling edge so the driver's updates have settled
   task automatic wait_idle();
      while (sample_queue.size() != 0 || req_valid || expected_events.size() != 0)
         @(negedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic queue_sample(input logic [2:0] b, input logic lvl, input logic [31:0] t);
      sample_type s;
      s = '{b, lvl, t};
      sample_queue.push_back(s);
   endtask

   // random scan traffic: mostly held levels with bounces, some time jumps anywhere
   task automatic queue_random_samples(input int wanted);
      int         taken;
      int         scale;
      int         roll;
      logic [2:0] b;
      logic       lvl;
      taken = 0;
      scale = (shadow_cfg.debounce_time > shadow_cfg.long_press_time) ?
              shadow_cfg.debounce_time : shadow_cfg.long_press_time;
      while (taken < wanted) begin
         b = 3'($urandom_range(0, NUM_BUTTONS - 1));
         // disabled buttons only now and then, they are ignored anyway
         if (!shadow_cfg.enable_mask[b] && $urandom_range(0, 99) < 85) continue;
         if ($urandom_range(0, 99) < 8) target_level[b] = ~target_level[b];
         lvl = target_level[b];
         // contact bounce for one sample
         if ($urandom_range(0, 99) < 10) lvl = ~lvl;
         roll = $urandom_range(0, 99);
         if (roll < 3)
            scan_ms = $urandom();
         else if (roll < 15)
            scan_ms += $urandom_range(0, 2 * scale + 8);
         else
            scan_ms += $urandom_range(0, scale / 4 + 3);
         queue_sample(b, lvl, scan_ms);
         if (shadow_cfg.enable_mask[b]) taken++;
      end
   endtask

   initial begin
      logic [15:0] db;
      logic [15:0] lp;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset setting: nothing enabled, samples must vanish
      queue_sample(3'd0, 1'b0, 32'd100);
      queue_sample(3'd7, 1'b0, 32'd200);
      wait_idle();

      // defaults with all buttons on, active low: press on the debounce edge,
      // long press after the hold time, release, and a press across the time wrap
      apply_setting(16'd50, 16'd1000, 8'hFF, 8'hFF);
      queue_sample(3'd0, 1'b0, 32'd1000);
      queue_sample(3'd0, 1'b0, 32'd1049);
      queue_sample(3'd0, 1'b0, 32'd1050);
      queue_sample(3'd0, 1'b0, 32'd2049);
      queue_sample(3'd0, 1'b0, 32'd2050);
      queue_sample(3'd0, 1'b1, 32'd2100);
      queue_sample(3'd0, 1'b1, 32'd2150);
      queue_sample(3'd7, 1'b0, 32'hFFFF_FFF0);
      queue_sample(3'd7, 1'b0, 32'h0000_0022);
      wait_idle();

      // zero times, active high: press and long press from one sample
      apply_setting(16'd0, 16'd0, 8'h00, 8'hFF);
      queue_sample(3'd3, 1'b1, 32'd0);
      queue_sample(3'd3, 1'b0, 32'hFFFF_FFFF);
      queue_sample(3'd5, 1'b1, 32'd10);
      wait_idle();

      // polarity flip on a held button reads as a change of level
      apply_setting(16'd0, 16'd0, 8'h20, 8'hFF);
      queue_sample(3'd5, 1'b1, 32'd20);
      wait_idle();

      // longest debounce and hold times, one short of the edge and on it
      apply_setting(16'hFFFF, 16'hFFFF, 8'h00, 8'hFF);
      queue_sample(3'd1, 1'b1, 32'd100);
      queue_sample(3'd1, 1'b1, 32'd100 + 32'd65534);
      queue_sample(3'd1, 1'b1, 32'd100 + 32'd65535);
      queue_sample(3'd1, 1'b1, 32'd100 + 32'd131070);
      wait_idle();

      // random phases, one setting each
      scan_ms = 32'h0010_0000;
      for (int p = 0; p < 8; p++) begin
         db = 16'($urandom_range(0, 25));
         lp = 16'($urandom_range(0, 300));
         case (p)
            0: apply_setting(16'($urandom_range(0, 15)), 16'($urandom_range(0, 150)),
                             8'($urandom()), 8'hFF);
            1: apply_setting(16'd0, 16'd0, 8'h00, 8'($urandom_range(1, 255)));
            2: begin
               // long times with big steps, starting just short of the wrap
               apply_setting(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
               scan_ms = 32'hFFF0_0000;
            end
            3: begin
               // the stretch where neither side idles
               apply_setting(16'($urandom_range(0, 40)), 16'($urandom_range(0, 400)),
                             8'($urandom()), 8'($urandom_range(1, 255)));
               calm = 1'b1;
            end
            default: apply_setting(db, lp, 8'($urandom()), 8'($urandom_range(1, 255)));
         endcase
         queue_random_samples(250);
         wait_idle();
         calm = 1'b0;
      end

      $display("summary: %0d samples over %0d register settings, %0d events checked",
               samples_sent, settings_used, events_seen);
      $display("summary: %0d press, %0d release, %0d long press, %0d mismatches",
               kind_count[KIND_PRESS], kind_count[KIND_RELEASE], kind_count[KIND_LONG],
               mismatch_count);
      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin
      #(5_000_000);
      $display("timeout: %0d events still expected", expected_events.size());
      $display("testbench: FAIL");
      $finish;
   end

endmodule
